FILE: rtl/kas_pkg.sv
package kas_pkg;

   // Vector and knot limits.
   localparam int MAX_ORDER  = 16;
   localparam int KNOT_WIDTH = 32;

   // Fixed field widths of the ports.
   localparam int ORDER_W  = 5;
   localparam int AVG_W    = 32;
   localparam int STATUS_W = 2;

   // Derived sizes.
   localparam int WIN_DEPTH = MAX_ORDER - 1;
   localparam int IDX_W     = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
   localparam int COUNT_W   = $clog2(MAX_ORDER + 1);
   localparam int SUM_W     = KNOT_WIDTH + $clog2(WIN_DEPTH);
   localparam int DIV_W     = $clog2(MAX_ORDER);
   localparam int STEP_W    = $clog2(SUM_W + 1);

   localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(2);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_AVG   = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_SHORT = 2'd2
   } status_type;

endpackage

FILE: rtl/kas_stream_if.sv
interface kas_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [kas_pkg::KNOT_WIDTH-1:0] knot;
   logic                                 last;

   modport source (output valid, knot, last, input ready);
   modport sink (input valid, knot, last, output ready);
endinterface

interface kas_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [kas_pkg::AVG_W-1:0]    average;
   logic [kas_pkg::STATUS_W-1:0]       status;
   logic                               last_out;

   modport source (output valid, average, status, last_out, input ready);
   modport sink (input valid, average, status, last_out, output ready);
endinterface

FILE: rtl/knot_average_stream_top.sv
// Greville knot averages over a streamed knot vector.
// Requests arrive on req_if: one signed Q16.16 knot per request, with last set on
// the final knot of a vector. Results leave on rsp_if: an average (truncated toward
// zero), a status code and last_out. The spline order resets to 2; the user must
// write it through csr_we and csr_wdata only while the block is idle, which the
// block does not enforce. Knot m of a vector (from 0) with m >= order gives the
// mean of the order-1 knots before it. A vector that ends without any average
// gives one status response: empty when its length equals order, too short when
// it is less. A knot that gives an average is summed one window entry per cycle,
// then divided by order-1 in a radix-2 restoring divider that retires one quotient
// bit per cycle over the 36-bit sum; the result is loaded into the output register
// in ST_FIN, and the next request is taken back in ST_IDLE. A knot with no average
// goes straight from ST_IDLE to ST_FIN. One knot is in work at a time.
// The response sits in an output register, so the next request is accepted while
// it waits. If rsp_if.ready stays low, the following result is held inside the
// block until the output register frees up, and no request is taken meanwhile.
// Reset is synchronous: it drops any work in flight and any pending response,
// clears the vector counters and sets the order back to 2.
module knot_average_stream_top (
   input  logic                         clock,
   input  logic                         reset,
   kas_req_if.sink                      req_if,
   kas_rsp_if.source                    rsp_if,
   input  logic                         csr_we,
   input  logic [kas_pkg::ORDER_W-1:0]  csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_ABS,
      ST_DIV,
      ST_FIN
   } state_type;

   state_type                              state_ff, state_in;
   logic [kas_pkg::ORDER_W-1:0]            order_ff, order_in;
   logic signed [kas_pkg::KNOT_WIDTH-1:0]  window_ff [kas_pkg::WIN_DEPTH];
   logic signed [kas_pkg::KNOT_WIDTH-1:0]  window_in [kas_pkg::WIN_DEPTH];
   logic signed [kas_pkg::KNOT_WIDTH-1:0]  knot_ff, knot_in;
   logic                                   last_ff, last_in;
   logic [kas_pkg::COUNT_W-1:0]            k_ff, k_in;
   logic [kas_pkg::COUNT_W-1:0]            count_ff, count_in;
   logic                                   emitted_ff, emitted_in;
   logic                                   emit_now_ff, emit_now_in;
   logic [kas_pkg::IDX_W-1:0]              idx_ff, idx_in;
   logic [kas_pkg::SUM_W-1:0]              acc_ff, acc_in;
   logic [kas_pkg::DIV_W-1:0]              rem_ff, rem_in;
   logic [kas_pkg::STEP_W-1:0]             step_ff, step_in;
   logic                                   neg_ff, neg_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic signed [kas_pkg::AVG_W-1:0]       rsp_average_ff, rsp_average_in;
   kas_pkg::status_type                    rsp_status_ff, rsp_status_in;
   logic                                   rsp_last_ff, rsp_last_in;

   logic [kas_pkg::COUNT_W-1:0]            eff_order;
   logic [kas_pkg::DIV_W-1:0]              divisor;
   logic [kas_pkg::DIV_W:0]                trial;
   logic                                   trial_ge;
   logic signed [kas_pkg::SUM_W-1:0]       win_ext;
   logic signed [kas_pkg::SUM_W-1:0]       quotient;
   logic                                   need_rsp;
   logic                                   rsp_free;

   always_comb begin
      if (order_ff < kas_pkg::ORDER_W'(2)) begin
         eff_order = kas_pkg::COUNT_W'(2);
      end else if (int'(order_ff) > kas_pkg::MAX_ORDER) begin
         eff_order = kas_pkg::COUNT_W'(kas_pkg::MAX_ORDER);
      end else begin
         eff_order = kas_pkg::COUNT_W'(order_ff);
      end
   end

   assign divisor  = kas_pkg::DIV_W'(k_ff - kas_pkg::COUNT_W'(1));
   assign trial    = {rem_ff, acc_ff[kas_pkg::SUM_W-1]};
   assign trial_ge = trial >= {1'b0, divisor};
   assign win_ext  = kas_pkg::SUM_W'(window_ff[idx_ff]);
   assign quotient = neg_ff ? -$signed(acc_ff) : $signed(acc_ff);
   // A response is due for an average, or as a status response when the vector ends without any average.
   assign need_rsp = emit_now_ff || (last_ff && !emitted_ff);
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   assign req_if.ready    = (state_ff == ST_IDLE);
   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.average  = rsp_average_ff;
   assign rsp_if.status   = rsp_status_ff;
   assign rsp_if.last_out = rsp_last_ff;

   always_comb begin
      state_in       = state_ff;
      order_in       = csr_we ? csr_wdata : order_ff;
      window_in      = window_ff;
      knot_in        = knot_ff;
      last_in        = last_ff;
      k_in           = k_ff;
      count_in       = count_ff;
      emitted_in     = emitted_ff;
      emit_now_in    = emit_now_ff;
      idx_in         = idx_ff;
      acc_in         = acc_ff;
      rem_in         = rem_ff;
      step_in        = step_ff;
      neg_in         = neg_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_average_in = rsp_average_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               knot_in     = req_if.knot;
               last_in     = req_if.last;
               k_in        = eff_order;
               emit_now_in = count_ff >= eff_order;
               idx_in      = '0;
               acc_in      = '0;
               state_in    = (count_ff >= eff_order) ? ST_SUM : ST_FIN;
            end
         end
         ST_SUM: begin
            acc_in = acc_ff + win_ext;
            idx_in = idx_ff + kas_pkg::IDX_W'(1);
            if (idx_ff == kas_pkg::IDX_W'(k_ff - kas_pkg::COUNT_W'(2))) begin
               state_in = ST_ABS;
            end
         end
         ST_ABS: begin
            // The divider works on the magnitude; the sign is put back at the end.
            neg_in   = acc_ff[kas_pkg::SUM_W-1];
            acc_in   = acc_ff[kas_pkg::SUM_W-1] ? -acc_ff : acc_ff;
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // Dividend bits shift out at the top while quotient bits enter below.
            rem_in  = trial_ge ? kas_pkg::DIV_W'(trial - {1'b0, divisor})
                               : kas_pkg::DIV_W'(trial);
            acc_in  = {acc_ff[kas_pkg::SUM_W-2:0], trial_ge};
            step_in = step_ff + kas_pkg::STEP_W'(1);
            if (step_ff == kas_pkg::STEP_W'(kas_pkg::SUM_W - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!need_rsp || rsp_free) begin
               if (need_rsp) begin
                  rsp_valid_in = 1'b1;
                  if (emit_now_ff) begin
                     rsp_average_in = kas_pkg::AVG_W'(quotient);
                     rsp_status_in  = kas_pkg::STATUS_AVG;
                     rsp_last_in    = last_ff;
                  end else begin
                     rsp_average_in = '0;
                     rsp_status_in  = ({1'b0, count_ff} + 1'b1 == {1'b0, k_ff})
                                      ? kas_pkg::STATUS_EMPTY : kas_pkg::STATUS_SHORT;
                     rsp_last_in    = 1'b1;
                  end
               end
               for (int i = kas_pkg::WIN_DEPTH - 1; i > 0; i--) begin
                  window_in[i] = window_ff[i-1];
               end
               window_in[0] = knot_ff;
               // Old window entries are never read before they are overwritten
               // in the next vector, so the end of a vector only clears counters.
               if (last_ff) begin
                  count_in   = '0;
                  emitted_in = 1'b0;
               end else begin
                  count_in   = (count_ff == kas_pkg::COUNT_W'(kas_pkg::MAX_ORDER))
                               ? count_ff : count_ff + kas_pkg::COUNT_W'(1);
                  emitted_in = emitted_ff || emit_now_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      window_ff      <= window_in;
      knot_ff        <= knot_in;
      last_ff        <= last_in;
      k_ff           <= k_in;
      emit_now_ff    <= emit_now_in;
      idx_ff         <= idx_in;
      acc_ff         <= acc_in;
      rem_ff         <= rem_in;
      step_ff        <= step_in;
      neg_ff         <= neg_in;
      rsp_average_ff <= rsp_average_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_last_ff    <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         order_ff     <= kas_pkg::ORDER_RESET;
         count_ff     <= '0;
         emitted_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         order_ff     <= order_in;
         count_ff     <= count_in;
         emitted_ff   <= emitted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/kas_checker.sv
module kas_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [kas_pkg::AVG_W-1:0]    rsp_average,
   input logic [kas_pkg::STATUS_W-1:0]        rsp_status,
   input logic                                rsp_last_out
);

   // A stalled response keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_average)
         && $stable(rsp_status) && $stable(rsp_last_out))
      else $error("stalled response changed");

   // Status responses close the vector and carry a zero average.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != kas_pkg::STATUS_AVG |-> rsp_last_out && rsp_average == '0)
      else $error("status response without last_out or with nonzero average");

   // Only one knot is in work at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while the previous one is in work");

   // A new response is loaded only while a knot is being finished.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response appeared without a knot in work");

endmodule

bind knot_average_stream_top kas_checker u_kas_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_average  (rsp_if.average),
   .rsp_status   (rsp_if.status),
   .rsp_last_out (rsp_if.last_out)
);
